/* hdl/ljpfe_pkg.sv */
// ----------------------------------------------------------------------------
// ljpfe_pkg
// Shared types, constants and binary32 arithmetic helpers for the
// Lennard-Jones pair force and energy pipeline.
// ----------------------------------------------------------------------------
package ljpfe_pkg;

   localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
   localparam logic [31:0] MIN_RSQ_BITS = 32'h2B8C_BCCC;  // 1e-12
   localparam logic [31:0] TWO_BITS     = 32'h4000_0000;  // 2.0
   localparam logic [31:0] FOUR_BITS    = 32'h4080_0000;  // 4.0
   localparam logic [31:0] TWENTY4_BITS = 32'h41C0_0000;  // 24.0

   localparam int RECIP_STEPS  = 4;                  // quotient bits per stage
   localparam int RECIP_STAGES = 7;                  // digit stages
   localparam int RECIP_LAT    = RECIP_STAGES + 2;   // unpack + digits + round
   localparam int POLY_STAGES  = 8;

   typedef struct packed {
      logic [31:0] sq;
      logic [31:0] e4;
      logic [31:0] f24;
      logic        near_zero;
      logic        last;
   } side_type;

   typedef struct packed {
      logic [31:0] force_bits;
      logic [31:0] energy_bits;
      logic        last;
   } result_type;

   // Normalize and round to nearest even. The value is
   // man_in / 2^48 * 2^(exp_in - 127); man_in must be nonzero.
   function automatic logic [31:0] fp_round_pack(input logic sign, input int exp_in,
                                                 input logic [49:0] man_in);
      int          e;
      int          msb;
      int          sh;
      int          rs;
      logic [49:0] m;
      logic [23:0] mant;
      logic [24:0] mant_r;
      logic        g;
      logic        st;
      logic        rup;
      logic [7:0]  ef;
      logic [31:0] res;
      e = exp_in;
      m = man_in;
      if (m[49]) begin
         m = {1'b0, m[49:2], m[1] | m[0]};
         e = e + 1;
      end else begin
         msb = 0;
         for (int i = 0; i < 49; i++) begin
            if (m[i]) msb = i;
         end
         sh = 48 - msb;
         if (e - sh < 1) sh = e - 1;
         if (sh > 0) begin
            m = m << sh;
            e = e - sh;
         end
      end
      // subnormal range: shift right, keep sticky
      if (e < 1) begin
         rs = 1 - e;
         if (rs > 49) begin
            m = {49'b0, |m};
         end else begin
            m = (m >> rs) | {49'b0, |(m & ((50'b1 << rs) - 50'b1))};
         end
         e = 1;
      end
      mant   = m[48:25];
      g      = m[24];
      st     = |m[23:0];
      rup    = g & (st | mant[0]);
      mant_r = {1'b0, mant} + {24'b0, rup};
      if (mant_r[24]) begin
         mant = 24'h80_0000;
         e    = e + 1;
      end else begin
         mant = mant_r[23:0];
      end
      if (e >= 255) begin
         res = {sign, 8'hFF, 23'b0};
      end else begin
         ef  = mant[23] ? 8'(e) : 8'd0;
         res = {sign, ef, mant[22:0]};
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        s;
      logic [7:0]  xa;
      logic [7:0]  xb;
      logic [23:0] ma;
      logic [23:0] mb;
      logic [47:0] p;
      logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
      logic [31:0] res;
      xa     = a[30:23];
      xb     = b[30:23];
      ma     = {xa != 8'd0, a[22:0]};
      mb     = {xb != 8'd0, b[22:0]};
      a_nan  = (xa == 8'hFF) && (a[22:0] != 23'd0);
      b_nan  = (xb == 8'hFF) && (b[22:0] != 23'd0);
      a_inf  = (xa == 8'hFF) && (a[22:0] == 23'd0);
      b_inf  = (xb == 8'hFF) && (b[22:0] == 23'd0);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      s      = a[31] ^ b[31];
      if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
         res = QNAN_BITS;
      end else if (a_inf || b_inf) begin
         res = {s, 8'hFF, 23'b0};
      end else if (a_zero || b_zero) begin
         res = {s, 31'b0};
      end else begin
         p   = ma * mb;
         res = fp_round_pack(s, int'((xa == 8'd0) ? 8'd1 : xa)
                              + int'((xb == 8'd0) ? 8'd1 : xb) - 125, {2'b0, p});
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_add(input logic [31:0] a_in, input logic [31:0] b_in);
      logic [31:0] a;
      logic [31:0] b;
      logic [7:0]  ea;
      logic [7:0]  eb;
      logic [49:0] ax;
      logic [49:0] bx;
      logic [49:0] sum;
      int          d;
      logic        a_nan, b_nan, a_inf, b_inf;
      logic [31:0] res;
      a_nan = (a_in[30:23] == 8'hFF) && (a_in[22:0] != 23'd0);
      b_nan = (b_in[30:23] == 8'hFF) && (b_in[22:0] != 23'd0);
      a_inf = (a_in[30:0] == 31'h7F80_0000);
      b_inf = (b_in[30:0] == 31'h7F80_0000);
      // larger magnitude goes to a
      if (a_in[30:0] < b_in[30:0]) begin
         a = b_in;
         b = a_in;
      end else begin
         a = a_in;
         b = b_in;
      end
      ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
      eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      ax = {1'b0, a[30:23] != 8'd0, a[22:0], 25'b0};
      bx = {1'b0, b[30:23] != 8'd0, b[22:0], 25'b0};
      d  = int'(ea) - int'(eb);
      if (d > 49) begin
         bx = {49'b0, |bx};
      end else begin
         bx = (bx >> d) | {49'b0, |(bx & ((50'b1 << d) - 50'b1))};
      end
      sum = (a[31] == b[31]) ? (ax + bx) : (ax - bx);
      if (a_nan || b_nan || (a_inf && b_inf && (a_in[31] != b_in[31]))) begin
         res = QNAN_BITS;
      end else if (a_inf) begin
         res = a_in;
      end else if (b_inf) begin
         res = b_in;
      end else if (sum == 50'd0) begin
         res = {a[31] & b[31], 31'b0};
      end else begin
         res = fp_round_pack(a[31], int'(ea), sum);
      end
      return res;
   endfunction

   function automatic logic [31:0] fp_neg(input logic [31:0] a);
      return {~a[31], a[30:0]};
   endfunction

endpackage

/* hdl/lj_pair_force_energy.sv */
// ----------------------------------------------------------------------------
// lj_pair_force_energy
// Lennard-Jones 12-6 force-over-r and energy for one atom pair per word.
// ----------------------------------------------------------------------------
// Takes one pair (r^2, epsilon, sigma as binary32 bit patterns plus a batch
// last flag) every clock cycle and returns 24*eps*(2*t12-t6)/r^2 and
// 4*eps*(t12-t6), t6 = (sigma^2/r^2)^3, rounded to nearest even after every
// operation with subnormals kept; any NaN result is 0x7FC00000, and r^2
// below 1e-12 (including zero and negatives) gives +0 on both outputs.
// The response word passes through 9 stages of reciprocal (unpack, seven
// 4-bit digit stages, rounding), 8 stages of multiply/add chain and the
// output register. Throughput is one pair per cycle; req_stall rises only
// when the skid entry behind a stalled response is occupied.
// ----------------------------------------------------------------------------
module lj_pair_force_energy
   import ljpfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_rsq_bits,
   input  logic [31:0] req_eps_bits,
   input  logic [31:0] req_sigma_bits,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_force_over_r_bits,
   output logic [31:0] rsp_energy_bits,
   output logic        rsp_out_last
);

   logic        en;
   logic        inv_valid;
   logic [31:0] inv_bits;
   side_type    side_ff [RECIP_LAT];
   side_type    side_in;
   logic        near_zero;
   logic        poly_valid;
   result_type  poly_result;
   result_type  rsp_data;

   assign req_stall = !en;

   // NaN never compares below the threshold
   assign near_zero = !((req_rsq_bits[30:23] == 8'hFF) && (req_rsq_bits[22:0] != 23'd0))
                      && (req_rsq_bits[31] || (req_rsq_bits < MIN_RSQ_BITS));

   always_comb begin
      side_in.sq        = fp_mul(req_sigma_bits, req_sigma_bits);
      side_in.e4        = fp_mul(FOUR_BITS, req_eps_bits);
      side_in.f24       = fp_mul(TWENTY4_BITS, req_eps_bits);
      side_in.near_zero = near_zero;
      side_in.last      = req_in_last;
   end

   // match the reciprocal latency
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int k = 1; k < RECIP_LAT; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   ljpfe_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .rsq_bits  (req_rsq_bits),
      .out_valid (inv_valid),
      .inv_bits  (inv_bits)
   );

   ljpfe_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (inv_valid),
      .inv_bits  (inv_bits),
      .side      (side_ff[RECIP_LAT-1]),
      .out_valid (poly_valid),
      .result    (poly_result)
   );

   ljpfe_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_data   (poly_result),
      .en        (en),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_force_over_r_bits = rsp_data.force_bits;
   assign rsp_energy_bits       = rsp_data.energy_bits;
   assign rsp_out_last          = rsp_data.last;

endmodule

/* hdl/ljpfe_recip.sv */
// ----------------------------------------------------------------------------
// ljpfe_recip
// Pipelined binary32 reciprocal 1/r^2: restoring digit recurrence, a few
// quotient bits per stage, then one rounding stage.
// ----------------------------------------------------------------------------
module ljpfe_recip
   import ljpfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] rsq_bits,
   output logic        out_valid,
   output logic [31:0] inv_bits
);

   typedef struct packed {
      logic        is_nan;
      logic        is_inf;
      logic        sign;
      logic [7:0]  er;
      logic [23:0] mr;
      logic [24:0] rem;
      logic [27:0] quo;
   } digit_type;

   digit_type   dig_ff [RECIP_STAGES+1];
   digit_type   dig_in [RECIP_STAGES+1];
   logic        dv_ff  [RECIP_STAGES+1];
   logic        inv_v_ff;
   logic [31:0] inv_ff;

   always_comb begin
      dig_in[0].is_nan = (rsq_bits[30:23] == 8'hFF) && (rsq_bits[22:0] != 23'd0);
      dig_in[0].is_inf = (rsq_bits[30:0] == 31'h7F80_0000);
      dig_in[0].sign   = rsq_bits[31];
      dig_in[0].er     = (rsq_bits[30:23] == 8'd0) ? 8'd1 : rsq_bits[30:23];
      dig_in[0].mr     = {rsq_bits[30:23] != 8'd0, rsq_bits[22:0]};
      dig_in[0].rem    = 25'h80_0000;
      dig_in[0].quo    = '0;
      for (int k = 1; k <= RECIP_STAGES; k++) begin
         dig_in[k] = dig_ff[k-1];
         for (int j = 0; j < RECIP_STEPS; j++) begin
            if (dig_in[k].rem >= {1'b0, dig_in[k].mr}) begin
               dig_in[k].rem = dig_in[k].rem - {1'b0, dig_in[k].mr};
               dig_in[k].quo = {dig_in[k].quo[26:0], 1'b1};
            end else begin
               dig_in[k].quo = {dig_in[k].quo[26:0], 1'b0};
            end
            dig_in[k].rem = {dig_in[k].rem[23:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= RECIP_STAGES; k++) dv_ff[k] <= 1'b0;
         inv_v_ff <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= in_valid;
         for (int k = 1; k <= RECIP_STAGES; k++) dv_ff[k] <= dv_ff[k-1];
         inv_v_ff <= dv_ff[RECIP_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= RECIP_STAGES; k++) dig_ff[k] <= dig_in[k];
         if (dig_ff[RECIP_STAGES].is_nan) begin
            inv_ff <= QNAN_BITS;
         end else if (dig_ff[RECIP_STAGES].is_inf) begin
            inv_ff <= {dig_ff[RECIP_STAGES].sign, 31'b0};
         end else begin
            inv_ff <= fp_round_pack(dig_ff[RECIP_STAGES].sign,
                                    253 - int'(dig_ff[RECIP_STAGES].er),
                                    {dig_ff[RECIP_STAGES].quo, 21'b0,
                                     dig_ff[RECIP_STAGES].rem != 25'd0});
         end
      end
   end

   assign out_valid = inv_v_ff;
   assign inv_bits  = inv_ff;

endmodule

/* hdl/ljpfe_poly.sv */
// ----------------------------------------------------------------------------
// ljpfe_poly
// Power chain and force/energy combination, one binary32 operation per
// stage on each path.
// ----------------------------------------------------------------------------
module ljpfe_poly
   import ljpfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] inv_bits,
   input  side_type    side,
   output logic        out_valid,
   output result_type  result
);

   typedef struct packed {
      logic [31:0] inv;
      logic [31:0] e4;
      logic [31:0] f24;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        near_zero;
      logic        last;
   } poly_type;

   poly_type pst_ff [1:POLY_STAGES];
   poly_type pst_in [1:POLY_STAGES];
   logic     pv_ff  [1:POLY_STAGES];

   always_comb begin
      // s = sq * inv
      pst_in[1].inv       = inv_bits;
      pst_in[1].e4        = side.e4;
      pst_in[1].f24       = side.f24;
      pst_in[1].x         = fp_mul(side.sq, inv_bits);
      pst_in[1].y         = '0;
      pst_in[1].z         = '0;
      pst_in[1].near_zero = side.near_zero;
      pst_in[1].last      = side.last;
      // t2 = s*s, keep s
      pst_in[2]   = pst_ff[1];
      pst_in[2].x = fp_mul(pst_ff[1].x, pst_ff[1].x);
      pst_in[2].y = pst_ff[1].x;
      // t6 = t2*s
      pst_in[3]   = pst_ff[2];
      pst_in[3].x = fp_mul(pst_ff[2].x, pst_ff[2].y);
      // t12 = t6*t6, keep t6
      pst_in[4]   = pst_ff[3];
      pst_in[4].x = fp_mul(pst_ff[3].x, pst_ff[3].x);
      pst_in[4].y = pst_ff[3].x;
      // diff = t12 - t6, two12 = 2*t12, keep t6
      pst_in[5]   = pst_ff[4];
      pst_in[5].x = fp_add(pst_ff[4].x, fp_neg(pst_ff[4].y));
      pst_in[5].y = fp_mul(TWO_BITS, pst_ff[4].x);
      pst_in[5].z = pst_ff[4].y;
      // energy = e4*diff, term = two12 - t6
      pst_in[6]   = pst_ff[5];
      pst_in[6].x = fp_mul(pst_ff[5].e4, pst_ff[5].x);
      pst_in[6].y = fp_add(pst_ff[5].y, fp_neg(pst_ff[5].z));
      // fp = f24*term
      pst_in[7]   = pst_ff[6];
      pst_in[7].y = fp_mul(pst_ff[6].f24, pst_ff[6].y);
      // force = fp*inv
      pst_in[8]   = pst_ff[7];
      pst_in[8].y = fp_mul(pst_ff[7].y, pst_ff[7].inv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= POLY_STAGES; k++) pv_ff[k] <= 1'b0;
      end else if (en) begin
         pv_ff[1] <= in_valid;
         for (int k = 2; k <= POLY_STAGES; k++) pv_ff[k] <= pv_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 1; k <= POLY_STAGES; k++) pst_ff[k] <= pst_in[k];
      end
   end

   // too-close pairs give zero on both outputs
   assign out_valid          = pv_ff[POLY_STAGES];
   assign result.force_bits  = pst_ff[POLY_STAGES].near_zero ? 32'd0 : pst_ff[POLY_STAGES].y;
   assign result.energy_bits = pst_ff[POLY_STAGES].near_zero ? 32'd0 : pst_ff[POLY_STAGES].x;
   assign result.last        = pst_ff[POLY_STAGES].last;

endmodule

/* hdl/ljpfe_outbuf.sv */
// ----------------------------------------------------------------------------
// ljpfe_outbuf
// Output register with a skid entry; the pipeline runs while the skid
// entry is empty.
// ----------------------------------------------------------------------------
module ljpfe_outbuf
   import ljpfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  result_type  in_data,
   output logic        en,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output result_type  rsp_data
);

   logic       out_v_ff;
   logic       skid_v_ff;
   result_type out_ff;
   result_type skid_ff;
   logic       take;

   assign en   = !skid_v_ff;
   assign take = !out_v_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (take) begin
         out_v_ff  <= skid_v_ff || in_valid;
         skid_v_ff <= 1'b0;
      end else if (in_valid && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= skid_v_ff ? skid_ff : in_data;
      end
      // park the word while the output is held
      if (!take && !skid_v_ff) begin
         skid_ff <= in_data;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

endmodule

/* verif/lj_pair_force_energy_test.sv */
// ----------------------------------------------------------------------------
// lj_pair_force_energy_test
// Self-checking testbench for the Lennard-Jones pair force/energy pipeline.
// ----------------------------------------------------------------------------
// Streams directed and random pairs through the request channel and checks
// each response word against a binary32 force/energy predictor. The
// predictor rounds every operation to single precision from an exact or
// double result. Sender gaps and receiver stalls vary by phase, and one
// long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module lj_pair_force_energy_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_CYCLES    = 150;
   localparam int SHOW_LIMIT     = 10;
   localparam logic [31:0] THRESH_BITS = 32'h2B8C_BCCC;
   localparam logic [31:0] NAN_BITS    = 32'h7FC0_0000;

   typedef struct {
      logic [31:0] rsq;
      logic [31:0] eps;
      logic [31:0] sigma;
      logic        last;
   } pair_type;

   typedef struct {
      logic [31:0] force_bits;
      logic [31:0] energy_bits;
      logic        last;
   } lj_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_rsq_bits = '0;
   logic [31:0] req_eps_bits = '0;
   logic [31:0] req_sigma_bits = '0;
   logic        req_in_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_force_over_r_bits;
   logic [31:0] rsp_energy_bits;
   logic        rsp_out_last;

   pair_type   pending_pairs[$];
   lj_out_type expected_lj[$];
   int         send_idle_pct = 0;
   int         stall_pct = 0;
   bit         hold_go = 1'b0;
   bit         hold_seen = 1'b0;
   int         hold_cnt = 0;
   bit         req_took = 1'b0;
   int         mismatches = 0;
   int         quiet_cycles = 0;

   lj_pair_force_energy u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rsq_bits          (req_rsq_bits),
      .req_eps_bits          (req_eps_bits),
      .req_sigma_bits        (req_sigma_bits),
      .req_in_last           (req_in_last),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_force_over_r_bits (rsp_force_over_r_bits),
      .rsp_energy_bits       (rsp_energy_bits),
      .rsp_out_last          (rsp_out_last)
   );

   always #5 clock = ~clock;

   // binary32 pattern to double, exact
   function automatic real single_to_real(input logic [31:0] f);
      int          p;
      logic [63:0] d;
      p = 0;
      if (f[30:23] == 8'hFF) begin
         d = (f[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {f[31], 11'h7FF, 52'b0};
      end else if (f[30:0] == 0) begin
         d = {f[31], 63'b0};
      end else if (f[30:23] == 0) begin
         for (int i = 0; i < 23; i++) if (f[i]) p = i;
         d = {f[31], 11'(p - 149 + 1023), 52'(64'(f[22:0]) << (52 - p))};
      end else begin
         d = {f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'b0};
      end
      return $bitstoreal(d);
   endfunction

   // double to binary32 with round to nearest even, subnormals kept
   function automatic logic [31:0] real_to_single(input real x);
      logic [63:0] b;
      logic [63:0] sig;
      logic [63:0] kept;
      logic [63:0] rem;
      logic [63:0] half;
      logic [31:0] r;
      int          fe;
      int          sh;
      b = $realtobits(x);
      if (b[62:52] == 11'h7FF) return (b[51:0] != 0) ? NAN_BITS : {b[63], 8'hFF, 23'b0};
      if (b[62:52] == 0) return {b[63], 31'b0};
      sig = {11'b0, 1'b1, b[51:0]};
      fe = int'(b[62:52]) - 1023 + 127;
      if (fe >= 255) return {b[63], 8'hFF, 23'b0};
      sh = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 60) sh = 60;
      kept = sig >> sh;
      rem  = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
      if (fe >= 1) r = 32'((64'(fe) << 23) + kept - (64'd1 << 23));
      else r = kept[31:0];
      return {b[63], r[30:0]};
   endfunction

   function automatic real rnd(input real x);
      return single_to_real(real_to_single(x));
   endfunction

   function automatic lj_out_type lj_force_energy(input pair_type p);
      lj_out_type o;
      real        r2, eps, sg, sq, inv, s, t6, t12, energy, force_val;
      r2  = single_to_real(p.rsq);
      eps = single_to_real(p.eps);
      sg  = single_to_real(p.sigma);
      o.last = p.last;
      if (r2 < single_to_real(THRESH_BITS)) begin
         o.force_bits  = '0;
         o.energy_bits = '0;
         return o;
      end
      sq  = rnd(sg * sg);
      inv = rnd(1.0 / r2);
      s   = rnd(sq * inv);
      t6  = rnd(rnd(s * s) * s);
      t12 = rnd(t6 * t6);
      energy    = rnd(rnd(4.0 * eps) * rnd(t12 - t6));
      force_val = rnd(rnd(rnd(24.0 * eps) * rnd(rnd(2.0 * t12) - t6)) * inv);
      o.force_bits  = real_to_single(force_val);
      o.energy_bits = real_to_single(energy);
      return o;
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000 | $urandom_range(0, 3);
         2: return 32'h7F80_0000 | ($urandom_range(0, 1) << 31);
         3: return 32'h7F80_0000 | $urandom_range(1, 32'h7F_FFFF) | ($urandom_range(0, 1) << 31);
         4: return $urandom_range(1, 32'h7F_FFFF);
         default: return $urandom();
      endcase
   endfunction

   function automatic pair_type rand_pair();
      pair_type p;
      p.last = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 70) begin
         // physical pair
         p.rsq   = real_to_single(0.05 + $urandom_range(0, 1000000) * 2.0e-5);
         p.eps   = real_to_single(0.001 + $urandom_range(0, 1000000) * 1.0e-6);
         p.sigma = real_to_single(0.2 + $urandom_range(0, 1000000) * 3.0e-6);
         if ($urandom_range(0, 9) == 0) p.rsq = THRESH_BITS + $urandom_range(0, 4) - 2;
      end else begin
         p.rsq   = rand_field();
         p.eps   = rand_field();
         p.sigma = rand_field();
      end
      return p;
   endfunction

   task automatic add_pair(input logic [31:0] r, input logic [31:0] e, input logic [31:0] s,
                           input logic l);
      pair_type p;
      p.rsq = r;
      p.eps = e;
      p.sigma = s;
      p.last = l;
      pending_pairs.push_back(p);
   endtask

   task automatic run_phase(input int n, input int idle_pct, input int st_pct);
      send_idle_pct = idle_pct;
      stall_pct = st_pct;
      repeat (n) pending_pairs.push_back(rand_pair());
      while (pending_pairs.size() != 0 || req_valid || expected_lj.size() != 0)
         @(posedge clock);
   endtask

   // sender: advance on acceptance, insert random gaps
   always @(negedge clock) begin
      pair_type p;
      if (reset || (req_valid && !req_took)) begin
      end else if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         p = pending_pairs.pop_front();
         req_rsq_bits   <= p.rsq;
         req_eps_bits   <= p.eps;
         req_sigma_bits <= p.sigma;
         req_in_last    <= p.last;
         req_valid      <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver: random stall plus one long hold
   always @(negedge clock) begin
      if (hold_go && !hold_seen) begin
         hold_seen = 1'b1;
         hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) hold_cnt = hold_cnt - 1;
      rsp_stall <= (hold_cnt > 0) || ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      pair_type   p;
      lj_out_type exp_o;
      req_took = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         req_took = 1'b1;
         p.rsq = req_rsq_bits;
         p.eps = req_eps_bits;
         p.sigma = req_sigma_bits;
         p.last = req_in_last;
         expected_lj.push_back(lj_force_energy(p));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lj.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("unexpected word: force %h energy %h last %b",
                        rsp_force_over_r_bits, rsp_energy_bits, rsp_out_last);
         end else begin
            exp_o = expected_lj.pop_front();
            if (exp_o.force_bits !== rsp_force_over_r_bits
                || exp_o.energy_bits !== rsp_energy_bits || exp_o.last !== rsp_out_last) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("mismatch: exp force %h energy %h last %b, got %h %h %b",
                           exp_o.force_bits, exp_o.energy_bits, exp_o.last,
                           rsp_force_over_r_bits, rsp_energy_bits, rsp_out_last);
            end
         end
      end
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      // short distance: zeros, negatives, just under and at threshold
      add_pair(32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_pair(32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1);
      add_pair(32'hBF80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      add_pair(THRESH_BITS - 1, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_pair(THRESH_BITS, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_pair(32'h0000_0001, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      // NaN, infinity and overflow
      add_pair(32'h7FC0_0001, 32'h3F80_0000, 32'h3F80_0000, 1'b1);
      add_pair(32'h7F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_pair(32'h7F7F_FFFF, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_pair(32'h3F80_0000, 32'h7F80_0000, 32'h3F80_0000, 1'b1);
      add_pair(32'h3F80_0000, 32'h7FFF_FFFF, 32'h3F80_0000, 1'b0);
      add_pair(32'h3F80_0000, 32'h3F80_0000, 32'h7F7F_FFFF, 1'b0);
      add_pair(32'h3F80_0000, 32'h3F80_0000, 32'h0000_0000, 1'b1);
      add_pair(32'h3F80_0000, 32'h3F80_0000, 32'h0000_0001, 1'b0);
      // ordinary pairs, negative epsilon and sigma
      add_pair(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      add_pair(32'h4000_0000, 32'hBF00_0000, 32'hBF80_0000, 1'b1);
      add_pair(32'h3E80_0000, 32'h3DCC_CCCD, 32'h3F4C_CCCD, 1'b0);
      add_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
      add_pair(32'h0080_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
      run_phase(0, 0, 0);
      run_phase(146, 0, 0);
      // long receiver hold while the sender keeps offering
      hold_go = 1'b1;
      run_phase(146, 0, 0);
      run_phase(146, 47, 0);
      run_phase(146, 0, 47);
      run_phase(146, 12, 12);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_lj.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* lj_pair_force_energy.f */
hdl/ljpfe_pkg.sv
hdl/ljpfe_recip.sv
hdl/ljpfe_poly.sv
hdl/ljpfe_outbuf.sv
hdl/lj_pair_force_energy.sv
verif/lj_pair_force_energy_test.sv
